// ===== rtl/u2a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types and constants for the unsigned to ASCII radix converter.
// ----------------------------------------------------------------------------
package u2a_pkg;

    // radix select codes carried on the input tuser
    typedef enum logic [1:0] {
        RADIX_DEC       = 2'd0,
        RADIX_OCT       = 2'd1,
        RADIX_HEX_LOWER = 2'd2,
        RADIX_HEX_UPPER = 2'd3
    } t_radix;

    // controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // digit bases and character offsets
    localparam logic [4:0] DEC_BASE         = 5'd10;
    localparam logic [4:0] OCT_BASE         = 5'd8;
    localparam logic [4:0] HEX_BASE         = 5'd16;
    localparam logic [6:0] ASCII_ZERO       = 7'd48;
    localparam logic [6:0] LOWER_HEX_OFFSET = 7'd39;
    localparam logic [6:0] UPPER_HEX_OFFSET = 7'd7;

    // widths of the output item fields
    localparam int CHAR_CODE_W  = 7;
    localparam int CHAR_COUNT_W = 4;
    localparam int OUT_DATA_W   = 16;

endpackage : u2a_pkg
`default_nettype wire

// ===== rtl/unsigned_to_ascii_radix_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_top
// Converts an unsigned number to ASCII digits in decimal, octal or hex,
// most significant digit first, with no leading zeros.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: value, tuser: radix
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: char_code, char_count
//                                                 tlast: last
//
//  a number goes from accept through one load per input bit, a scan that
//  drops leading zeros, and the emit state, which loads one character into
//  the output register whenever that register is free
//  the next number is accepted once the last character is in the output
//  register, even while that character still waits on i_m_axis_tready
//  output stalls hold the emit sequence; i_rst_n clears all control state
// ----------------------------------------------------------------------------
module unsigned_to_ascii_radix_top
    import u2a_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // bits up from 0: value [VALUE_WIDTH-1:0], zero fill to whole bytes
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // bits up from 0: radix [1:0]
    input  wire logic [1:0]           i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // bits up from 0: char_code [6:0], char_count [10:7], zero fill [15:11]
    output logic [OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);

    // digit slot count: enough for octal, the longest radix
    localparam int NDIG      = (VALUE_WIDTH + 2) / 3;
    localparam int DIG_W     = NDIG * 4;
    localparam int POS_W     = $clog2(NDIG + 1);
    localparam int CNT_W     = (POS_W > CHAR_COUNT_W) ? POS_W : CHAR_COUNT_W;
    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
    localparam int FILL_W    = OUT_DATA_W - CHAR_CODE_W - CHAR_COUNT_W;

    t_state                  r_state, n_state;
    t_radix                  r_radix, n_radix;
    logic [VALUE_WIDTH-1:0]  r_val, n_val;
    logic [DIG_W-1:0]        r_dig, n_dig;
    logic [BIT_CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_last, n_out_last;
    logic [CHAR_CODE_W-1:0]  r_out_code, n_out_code;
    logic [CHAR_COUNT_W-1:0] r_out_count, n_out_count;

    logic [4:0]              base;
    logic [3:0]              half;
    logic [NDIG-1:0]         ge;
    logic [NDIG-1:0]         cin;
    logic [DIG_W-1:0]        dig_step;
    logic [3:0]              top_dig;
    logic [CHAR_CODE_W-1:0]  char_code;
    logic [CNT_W-1:0]        cnt_p1;
    logic                    out_free;
    logic                    in_fire;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign top_dig         = r_dig[DIG_W-1 -: 4];
    assign cnt_p1          = r_cnt + CNT_W'(1);

    // base of the selected radix
    always_comb begin
        unique case (r_radix)
            RADIX_DEC: base = DEC_BASE;
            RADIX_OCT: base = OCT_BASE;
            default:   base = HEX_BASE;
        endcase
        half = base[4:1];
    end

    // one input bit into every digit: d = 2d + carry, reduced by the base
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            ge[i] = (r_dig[i*4 +: 4] >= half);
        end
        cin = {ge[NDIG-2:0], r_val[VALUE_WIDTH-1]};
        for (int i = 0; i < NDIG; i++) begin
            dig_step[i*4 +: 4] = 4'({1'b0, r_dig[i*4 +: 4], cin[i]}
                                    - (ge[i] ? base : 5'd0));
        end
    end

    // ascii code of the leading digit
    always_comb begin
        char_code = ASCII_ZERO + CHAR_CODE_W'(top_dig);
        if (top_dig >= 4'd10) begin
            char_code = char_code + ((r_radix == RADIX_HEX_UPPER) ?
                                     UPPER_HEX_OFFSET : LOWER_HEX_OFFSET);
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_val       = r_val;
        n_dig       = r_dig;
        n_bit_cnt   = r_bit_cnt;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_code  = r_out_code;
        n_out_count = r_out_count;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_val     = i_s_axis_tdata[VALUE_WIDTH-1:0];
                    n_radix   = t_radix'(i_s_axis_tuser);
                    n_dig     = '0;
                    n_bit_cnt = BIT_CNT_W'(VALUE_WIDTH - 1);
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                n_dig     = dig_step;
                n_val     = {r_val[VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
                if (r_bit_cnt == '0) begin
                    n_pos   = POS_W'(NDIG);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // drop leading zeros, always keep the final digit
                if (top_dig == 4'd0 && r_pos != POS_W'(1)) begin
                    n_dig = {r_dig[DIG_W-5:0], 4'd0};
                    n_pos = r_pos - POS_W'(1);
                end else begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = char_code;
                    n_out_last  = (r_pos == POS_W'(1));
                    n_out_count = (r_pos == POS_W'(1)) ?
                                  cnt_p1[CHAR_COUNT_W-1:0] : '0;
                    n_dig       = {r_dig[DIG_W-5:0], 4'd0};
                    n_pos       = r_pos - POS_W'(1);
                    n_cnt       = cnt_p1;
                    if (r_pos == POS_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_radix     <= n_radix;
        r_val       <= n_val;
        r_dig       <= n_dig;
        r_bit_cnt   <= n_bit_cnt;
        r_cnt       <= n_cnt;
        r_out_last  <= n_out_last;
        r_out_code  <= n_out_code;
        r_out_count <= n_out_count;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{FILL_W{1'b0}}, r_out_count, r_out_code};

    // the leading decimal digit never leaves 0..9 while bits shift in
    a_dec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_radix == RADIX_DEC) |-> (top_dig < 4'd10))
        else $error("decimal digit out of range during load");

    // a digit position is always pending while scanning or emitting
    a_pos_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_EMIT) |-> (r_pos != '0))
        else $error("digit position underflow");

    // only the final character carries a count
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_count == '0))
        else $error("character count on a non-final character");

    // emitted codes lie in the range from '0' to 'f'
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code >= 7'd48 && r_out_code <= 7'd102))
        else $error("character code out of range");

    // the last character returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_pos == POS_W'(1)) |=>
        (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final character did not end the number");

endmodule : unsigned_to_ascii_radix_top
`default_nettype wire
